[hw/rtl/sxc_pkg.sv]
// Shared types and constants for the secp256k1 x-coordinate check.
// No dependencies.
`default_nettype none
package sxc_pkg;
  localparam int LimbW = 32;
  localparam int NLimb = 8;
  localparam logic [255:0] PrimeP =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
  localparam logic [255:0] ExpSqrt =
    256'h3FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_BFFFFF0C;
  localparam logic [9:0] FoldLo = 10'd977;

  // Operand slots in the working memory.
  typedef enum logic [1:0] {
    SLOT_X   = 2'd0,
    SLOT_R   = 2'd1,
    SLOT_ACC = 2'd2,
    SLOT_SQ  = 2'd3
  } slot_t;

  typedef struct packed {
    logic         start;
    logic [255:0] a;
    logic [255:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

[hw/rtl/sxc_modmul.sv]
// Sequential 256-bit modular multiplier over the secp256k1 prime.
// Depends on sxc_pkg. 32x32 partial products one at a time, then folding.
`default_nettype none
module sxc_modmul
  import sxc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire mul_req_t     req,
  output logic              done,
  output logic [255:0]      prod
);
  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_MUL  = 4'b0010,
    M_FOLD = 4'b0100,
    M_FIN  = 4'b1000
  } mstate_t;

  mstate_t       st_r, st_nxt;
  logic [255:0]  a_r, b_r;
  logic [511:0]  t_r, t_nxt;
  logic [2:0]    i_r, j_r;
  logic [63:0]   pp_r;
  logic          pp_v_r;
  logic [5:0]    ai_sh_r;
  logic [3:0]    fk_r;
  logic [255:0]  h_r;
  logic [32:0]   fcarry_r;
  logic [255:0]  prod_r;
  logic          done_r;

  logic [31:0]   ai, bj;
  logic [63:0]   pp;
  logic [511:0]  pp_ext;
  logic [3:0]    fkm1;
  logic [31:0]   hk, hkm1, tk;
  logic [63:0]   fv;
  logic [256:0]  sub_v;

  assign ai = a_r[32*i_r +: 32];
  assign bj = b_r[32*j_r +: 32];
  assign pp = {32'd0, ai} * {32'd0, bj};
  assign pp_ext = {448'd0, pp_r};

  assign fkm1 = fk_r - 4'd1;
  assign hk   = (fk_r < 4'd8) ? h_r[32*fk_r[2:0] +: 32] : 32'd0;
  assign hkm1 = (fk_r >= 4'd1 && fk_r <= 4'd8) ? h_r[32*fkm1[2:0] +: 32] : 32'd0;
  assign tk   = (fk_r < 4'd8) ? t_r[32*fk_r[2:0] +: 32] : 32'd0;
  assign fv   = {32'd0, tk} + ({32'd0, hk} * {54'd0, FoldLo}) + {32'd0, hkm1}
              + {31'd0, fcarry_r};
  assign sub_v = {1'b0, t_r[255:0]} - {1'b0, PrimeP};

  always_comb begin
    st_nxt = st_r;
    t_nxt  = t_r;
    unique case (st_r)
      M_IDLE: if (req.start) st_nxt = M_MUL;
      M_MUL:  if (!pp_v_r && i_r == 3'd7 && j_r == 3'd7 && ai_sh_r == 6'd63) st_nxt = M_FOLD;
      M_FOLD: if (fk_r == 4'd9 && t_r[511:256] == 256'd0) st_nxt = M_FIN;
      M_FIN:  st_nxt = M_IDLE;
      default: st_nxt = M_IDLE;
    endcase
  end

  logic [5:0] pos;
  assign pos = {3'd0, i_r} + {3'd0, j_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= M_IDLE;
      pp_v_r  <= 1'b0;
      done_r  <= 1'b0;
      ai_sh_r <= 6'd0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      unique case (st_r)
        M_IDLE: begin
          a_r <= req.a; b_r <= req.b; t_r <= 512'd0;
          i_r <= 3'd0; j_r <= 3'd0; pp_v_r <= 1'b0; ai_sh_r <= 6'd0;
        end
        M_MUL: begin
          if (ai_sh_r != 6'd63) begin
            // Register one partial product, then accumulate it.
            if (!pp_v_r) begin
              pp_r   <= pp;
              pp_v_r <= 1'b1;
            end else begin
              t_r    <= t_r + (pp_ext << (10'd32 * {4'd0, pos}));
              pp_v_r <= 1'b0;
              if (j_r == 3'd7) begin
                j_r <= 3'd0;
                if (i_r == 3'd7) begin
                  ai_sh_r <= 6'd63;
                  j_r <= 3'd7;
                end else begin
                  i_r <= i_r + 3'd1;
                end
              end else begin
                j_r <= j_r + 3'd1;
              end
            end
          end
          if (ai_sh_r == 6'd63) begin
            fk_r <= 4'd0; h_r <= t_r[511:256]; fcarry_r <= 33'd0;
            t_r[511:256] <= 256'd0;
          end
        end
        M_FOLD: begin
          if (fk_r == 4'd9) begin
            fk_r <= 4'd0; h_r <= t_r[511:256]; fcarry_r <= 33'd0;
            t_r[511:256] <= 256'd0;
          end else begin
            // The top word can carry one bit past bit 287.
            if (fk_r < 4'd8) t_r[32*fk_r[2:0] +: 32] <= fv[31:0];
            else t_r[319:256] <= {31'd0, fv[32:0]};
            fcarry_r <= fv[63:31] >> 1;
            fk_r <= fk_r + 4'd1;
          end
        end
        M_FIN: begin
          prod_r <= sub_v[256] ? t_r[255:0] : sub_v[255:0];
          done_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign prod = prod_r;
endmodule
`default_nettype wire

[hw/rtl/secp256k1_x_on_curve_check_core.sv]
// Top level of the secp256k1 x-coordinate on-curve check.
// Depends on sxc_pkg and sxc_modmul.
`default_nettype none
// Usage: drive in_x_limb0..3 and raise start while busy is low; that edge
// accepts one transaction. The block reduces x mod p, forms r = x^3 + 7,
// raises r to (p+1)/4 by square-and-multiply, squares the root, and compares.
// All operands live in a small working memory of four 256-bit slots with a
// registered read; a sequencer reads the operands, runs one modular
// multiply on the shared multiplier, and writes the product back.
// Each multiply, after the read and issue steps, forms 64 partial products
// one at a time (each registered, then accumulated) and then folds the high
// half back in passes until it is zero; 256 squarings, 247 multiplies by r,
// and three more products make up a transaction, all on the one shared 32x32
// multiplier. busy stays high for the whole transaction.
// The result appears on out_* for exactly one cycle with out_valid high;
// the receiver cannot stall, so the result must be taken in that cycle.
// A new transaction may be started in the cycle after out_valid.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// busy and out_valid; no memory content needs clearing.
module secp256k1_x_on_curve_check_core
  import sxc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_x_limb0,
  input  wire logic [63:0] in_x_limb1,
  input  wire logic [63:0] in_x_limb2,
  input  wire logic [63:0] in_x_limb3,
  output logic             out_valid,
  output logic             out_on_curve,
  output logic [63:0]      out_y_limb0,
  output logic [63:0]      out_y_limb1,
  output logic [63:0]      out_y_limb2,
  output logic [63:0]      out_y_limb3
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_RD    = 8'b00000010,
    S_ISSUE = 8'b00000100,
    S_WAIT  = 8'b00001000,
    S_ADD7  = 8'b00010000,
    S_NEXT  = 8'b00100000,
    S_CMP   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  // Operation steps of the sequence.
  typedef enum logic [2:0] {
    OP_XX  = 3'd0,
    OP_XXX = 3'd1,
    OP_SQ  = 3'd2,
    OP_MR  = 3'd3,
    OP_FIN = 3'd4
  } op_t;

  state_t       st_r, st_nxt;
  op_t          op_r;
  logic [7:0]   bit_r;
  logic [255:0] mem [4];
  logic [255:0] rd_a_r, rd_b_r;
  slot_t        ra, rb, wa, wa_op;
  logic         we;
  logic [255:0] wd;
  mul_req_t     req;
  logic         mdone;
  logic [255:0] mprod;
  logic [256:0] xsub, r7, r7sub;
  logic         oc_r;
  logic         first_sq;

  sxc_modmul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .done(mdone), .prod(mprod));

  assign xsub  = {1'b0, in_x_limb3, in_x_limb2, in_x_limb1, in_x_limb0} - {1'b0, PrimeP};
  assign r7    = {1'b0, rd_a_r} + 257'd7;
  assign r7sub = r7 - {1'b0, PrimeP};

  always_comb begin
    ra = SLOT_ACC; rb = SLOT_ACC; wa_op = SLOT_ACC;
    unique case (op_r)
      OP_XX:  begin ra = SLOT_X;   rb = SLOT_X;   wa_op = SLOT_R;   end
      OP_XXX: begin ra = SLOT_R;   rb = SLOT_X;   wa_op = SLOT_R;   end
      OP_SQ:  begin ra = SLOT_ACC; rb = SLOT_ACC; wa_op = SLOT_ACC; end
      OP_MR:  begin ra = SLOT_ACC; rb = SLOT_R;   wa_op = SLOT_ACC; end
      OP_FIN: begin ra = SLOT_ACC; rb = SLOT_ACC; wa_op = SLOT_SQ;  end
      default: ;
    endcase
    if (st_r == S_ADD7) ra = SLOT_R;
    // The last step fetches r and the square so the compare has them next cycle.
    if (st_r == S_NEXT && op_r == OP_FIN) begin
      ra = SLOT_R;
      rb = SLOT_SQ;
    end
  end

  always_comb begin
    we = 1'b0; wd = mprod; wa = wa_op;
    if (st_r == S_IDLE && start) begin
      we = 1'b1; wa = SLOT_X;
      wd = xsub[256] ? {in_x_limb3, in_x_limb2, in_x_limb1, in_x_limb0} : xsub[255:0];
    end else if (st_r == S_WAIT && mdone) begin
      we = 1'b1;
    end else if (st_r == S_ADD7 && op_r == OP_SQ) begin
      we = 1'b1; wa = SLOT_R;
      wd = r7sub[256] ? r7[255:0] : r7sub[255:0];
    end
  end

  // Working memory: one write and two registered reads per cycle.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  // The accumulator starts at one, so the first squaring is fed 1 * 1.
  assign first_sq = (op_r == OP_SQ && bit_r == 8'd255);
  assign req = '{start: (st_r == S_ISSUE),
                 a:     (first_sq ? 256'd1 : rd_a_r),
                 b:     (first_sq ? 256'd1 : rd_b_r)};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (start) st_nxt = S_RD;
      S_RD:    st_nxt = S_ISSUE;
      S_ISSUE: st_nxt = S_WAIT;
      S_WAIT:  if (mdone) st_nxt = (op_r == OP_XXX) ? S_ADD7 : S_NEXT;
      S_ADD7:  st_nxt = (op_r == OP_SQ) ? S_RD : S_ADD7;
      S_NEXT:  st_nxt = (op_r == OP_FIN) ? S_CMP : S_RD;
      S_CMP:   st_nxt = S_OUT;
      S_OUT:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      op_r <= OP_XX;
      bit_r <= 8'd255;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_IDLE && start) begin
        op_r <= OP_XX; bit_r <= 8'd255;
      end
      if (st_r == S_WAIT && mdone && op_r == OP_XX) op_r <= OP_XXX;
      if (st_r == S_ADD7 && op_r == OP_XXX) op_r <= OP_SQ;
      if (st_r == S_NEXT) begin
        // Square-and-multiply over the exponent, most significant bit first.
        unique case (op_r)
          OP_SQ: begin
            if (ExpSqrt[bit_r]) op_r <= OP_MR;
            else if (bit_r == 8'd0) op_r <= OP_FIN;
            else bit_r <= bit_r - 8'd1;
          end
          OP_MR: begin
            if (bit_r == 8'd0) op_r <= OP_FIN;
            else begin op_r <= OP_SQ; bit_r <= bit_r - 8'd1; end
          end
          default: ;
        endcase
      end
      if (st_r == S_CMP) oc_r <= (rd_a_r == rd_b_r);
      // During the final squaring the A read port holds the root itself.
      if (st_r == S_NEXT && op_r == OP_FIN) begin
        out_y_limb0 <= rd_a_r[63:0];
        out_y_limb1 <= rd_a_r[127:64];
        out_y_limb2 <= rd_a_r[191:128];
        out_y_limb3 <= rd_a_r[255:192];
      end
    end
  end

  assign busy         = (st_r != S_IDLE);
  assign out_valid    = (st_r == S_OUT);
  assign out_on_curve = oc_r;
endmodule
`default_nettype wire
